>>> rtl/sma_pkg.sv
package sma_pkg;

  localparam int MAX_WINDOW_DEF   = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_WIDTH        = 10;
  localparam int WINDOW_RESET     = 1000;

endpackage

>>> rtl/sma_if.sv
interface sma_in_if
  import sma_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] price_sample;
  logic                           end_of_series;

  modport source (output valid, price_sample, end_of_series, input ready);
  modport sink   (input valid, price_sample, end_of_series, output ready);
endinterface

interface sma_out_if
  import sma_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;
  logic                           window_full;
  logic                           series_last;

  modport source (output valid, average, window_full, series_last, input ready);
  modport sink   (input valid, average, window_full, series_last, output ready);
endinterface

>>> rtl/simple_moving_average.sv
// Channel  Dir  Payload                                   Handshake
// in_ch    in   price_sample, end_of_series              valid / ready
// out_ch   out  average, window_full, series_last        valid / ready
// cfg      in   cfg_wdata (window_periods)               cfg_we, no wait
//
// One transaction steps through the states IDLE, RD, SUB, ADD, ABS, DIV and FIN;
// in DIV the restoring divider produces one quotient bit per cycle over the running sum.
// The sample ring has one write and one registered read port, one access each per item.
// Reset clears the window and loads window_periods with 1000; the ring is not cleared.
// A new sample is taken while a finished result still waits in the output register.
// The result is held in the divider until the output register frees up.
module simple_moving_average
  import sma_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sma_in_if.sink               in_ch,
  sma_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CNTE_W = CNT_W + 1;
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int CAP_W  = (CFG_WIDTH + 1 > CNT_W) ? CFG_WIDTH + 1 : CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_ABS  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];

  logic [2:0]              state_r, state_nxt;
  logic [CFG_WIDTH-1:0]    window_r, window_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic [PTR_W-1:0]        old_addr_r, old_addr_nxt;
  logic [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic                    last_r, last_nxt;
  logic                    full_r, full_nxt;
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic                    neg_r, neg_nxt;
  logic [SUM_W-1:0]        div_q_r, div_q_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_avg_r, out_avg_nxt;
  logic                    out_full_r, out_full_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [CAP_W-1:0]        cap_raw;
  logic [CNT_W-1:0]        cap;
  logic [CNTE_W-1:0]       wp_e, cap_e;
  logic [CNT_W:0]          rem_sh;
  logic [SUM_W-1:0]        sum_mag;
  logic [SAMPLE_WIDTH-1:0] q_mag;
  logic                    accept;
  logic                    out_free;

  assign cap_raw = CAP_W'(window_r) + CAP_W'(1);
  assign cap     = (cap_raw > CAP_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(cap_raw);
  assign wp_e    = CNTE_W'(wp_r);
  assign cap_e   = CNTE_W'(cap);
  assign rem_sh  = {rem_r, div_q_r[SUM_W-1]};
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q_mag   = div_q_r[SAMPLE_WIDTH-1:0];

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.average     = out_avg_r;
  assign out_ch.window_full = out_full_r;
  assign out_ch.series_last = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    old_addr_nxt  = old_addr_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    full_nxt      = full_r;
    neg_nxt       = neg_r;
    div_q_nxt     = div_q_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_avg_nxt   = out_avg_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          window_nxt = cfg_wdata;
          sum_nxt    = '0;
          fill_nxt   = '0;
          wp_nxt     = '0;
        end else if (accept) begin
          x_nxt    = in_ch.price_sample;
          last_nxt = in_ch.end_of_series;
          full_nxt = (fill_r >= cap);
          if (fill_r < cap) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (wp_e >= cap_e) begin
            old_addr_nxt = PTR_W'(wp_e - cap_e);
          end else begin
            old_addr_nxt = PTR_W'(wp_e + CNTE_W'(MAX_WINDOW) - cap_e);
          end
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        wp_nxt    = (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
        state_nxt = S_SUB;
      end
      S_SUB: begin
        if (full_r) begin
          sum_nxt = sum_r - {{(SUM_W-SAMPLE_WIDTH){rd_data_r[SAMPLE_WIDTH-1]}}, rd_data_r};
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt   = sum_r + {{(SUM_W-SAMPLE_WIDTH){x_r[SAMPLE_WIDTH-1]}}, x_r};
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt   = sum_r[SUM_W-1];
        div_q_nxt = sum_mag;
        rem_nxt   = '0;
        dcnt_nxt  = DCNT_W'(SUM_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, fill_r}) begin
          rem_nxt   = CNT_W'(rem_sh - {1'b0, fill_r});
          div_q_nxt = {div_q_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt   = CNT_W'(rem_sh);
          div_q_nxt = {div_q_r[SUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = neg_r ? -q_mag : q_mag;
          out_full_nxt  = (fill_r == cap);
          out_last_nxt  = last_r;
          if (last_r) begin
            sum_nxt  = '0;
            fill_nxt = '0;
            wp_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= CFG_WIDTH'(WINDOW_RESET);
      sum_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_addr_r <= old_addr_nxt;
    x_r        <= x_nxt;
    last_r     <= last_nxt;
    full_r     <= full_nxt;
    neg_r      <= neg_nxt;
    div_q_r    <= div_q_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    out_avg_r  <= out_avg_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

  // The read sees the old contents when the oldest slot is the one being written.
  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      ring_mem[wp_r] <= x_r;
      rd_data_r      <= ring_mem[old_addr_r];
    end
  end

  a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap)
    else $error("fill count exceeds window length");

  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |=> state_r == S_RD)
    else $error("accepted transaction did not start the ring read");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (rem_r < fill_r) && (fill_r != '0))
    else $error("divider remainder out of range");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the finish step");

endmodule

>>> bench/tb_simple_moving_average.sv
`timescale 1ns / 100ps

module tb_simple_moving_average;
  import sma_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH_DEF-1:0] average;
    logic                               window_full;
    logic                               series_last;
  } average_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  sma_in_if  in_ch();
  sma_out_if out_ch();

  simple_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [CFG_WIDTH-1:0]               span_setting;
  logic signed [SAMPLE_WIDTH_DEF-1:0] price_history [0:MAX_WINDOW_DEF-1];
  longint                             window_sum;
  int unsigned                        window_count;
  logic [CFG_WIDTH-1:0]               next_slot;
  average_result_t                    pending_averages [$];
  int                                 mismatches;
  bit                                 bursts_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("simple_moving_average regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  function automatic void clear_series();
    window_sum   = 0;
    window_count = 0;
    next_slot    = '0;
  endfunction

  function automatic void predict_average(input logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
                                          input logic last);
    int unsigned     span;
    int unsigned     oldest;
    longint          quotient;
    average_result_t want;
    span = span_setting + 1;
    if (span > MAX_WINDOW_DEF) begin
      span = MAX_WINDOW_DEF;
    end
    if (window_count >= span) begin
      oldest = (next_slot + MAX_WINDOW_DEF - span) % MAX_WINDOW_DEF;
      window_sum -= price_history[oldest];
    end else begin
      window_count++;
    end
    price_history[next_slot] = sample;
    window_sum += sample;
    next_slot = next_slot + 1'b1;
    quotient = window_sum / longint'(window_count);
    want.average     = quotient[SAMPLE_WIDTH_DEF-1:0];
    want.window_full = (window_count == span);
    want.series_last = last;
    pending_averages.push_back(want);
    if (last) begin
      clear_series();
    end
  endfunction

  // Valid stays high after a transaction so that back-to-back samples need one assignment.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
                             input logic last);
    int gap;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.price_sample  <= sample;
    in_ch.end_of_series <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_average(sample, last);
  endtask

  task automatic stop_samples();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_WIDTH-1:0] periods);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= periods;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_setting = periods;
    clear_series();
  endtask

  function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] random_price();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random_series(input int count, input int eos_odds);
    for (int i = 0; i < count; i++) begin
      send_sample(random_price(), $urandom_range(0, eos_odds) == 0);
    end
    stop_samples();
  endtask

  task automatic test_reset_window();
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd1, 1'b1);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b1);
    stop_samples();
  endtask

  task automatic test_zero_window();
    write_window('0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(-32'sd1, 1'b1);
    send_sample(32'sd1, 1'b0);
    stop_samples();
  endtask

  task automatic test_short_window();
    write_window(10'd1);
    send_sample(32'sd7, 1'b0);
    send_sample(-32'sd8, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b1);
    stop_samples();
  endtask

  task automatic test_clear_on_write();
    send_sample(32'sd100, 1'b0);
    send_sample(32'sd200, 1'b0);
    stop_samples();
    write_window(10'd1);
    send_sample(32'sd300, 1'b0);
    send_sample(-32'sd301, 1'b0);
    stop_samples();
  endtask

  task automatic test_random_windows();
    write_window('0);
    run_random_series(25, 6);
    write_window(10'($urandom_range(2, 15)));
    run_random_series(30, 12);
    write_window(10'($urandom_range(16, 60)));
    run_random_series(30, 40);
    write_window(10'd1);
    run_random_series(25, 6);
  endtask

  task automatic test_widest_window();
    write_window(10'd1023);
    for (int i = 0; i < 1030; i++) begin
      send_sample(random_price(), i == 1029);
    end
    stop_samples();
  endtask

  task automatic test_steady_stream();
    bursts_on = 1'b0;
    write_window(10'($urandom_range(2, 30)));
    run_random_series(40, 15);
  endtask

  initial begin : out_ready_driver
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    average_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("result transaction with no sample pending");
      end else begin
        want = pending_averages.pop_front();
        if (out_ch.average !== want.average) begin
          report_mismatch($sformatf("average %0d, expected %0d", out_ch.average, want.average));
        end
        if (out_ch.window_full !== want.window_full) begin
          report_mismatch($sformatf("window_full %b, expected %b",
                                    out_ch.window_full, want.window_full));
        end
        if (out_ch.series_last !== want.series_last) begin
          report_mismatch($sformatf("series_last %b, expected %b",
                                    out_ch.series_last, want.series_last));
        end
      end
    end
  end

  initial begin
    mismatches   = 0;
    bursts_on    = 1'b1;
    span_setting = WINDOW_RESET;
    clear_series();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.price_sample  <= '0;
    in_ch.end_of_series <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_zero_window();
    test_short_window();
    test_clear_on_write();
    test_random_windows();
    test_widest_window();
    test_steady_stream();
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("simple_moving_average regression: pass");
    end else begin
      $display("simple_moving_average regression: fail");
    end
    $finish;
  end

endmodule
